[rtl/uvlsc_pkg.sv]
// Shared types and codes for the UV lamp session controller.
package uvlsc_pkg;

  // Default sizing of the time and request id registers
  localparam int TIME_BITS_DEF = 32;
  localparam int ID_BITS_DEF   = 32;

  // Configuration register indexes
  localparam logic CFG_MAX_DURATION = 1'b0;
  localparam logic CFG_REQUIRED_POS = 1'b1;

  // Event operations
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ACTION    = 3'd1;
  localparam logic [2:0] OP_CANCEL    = 3'd2;
  localparam logic [2:0] OP_SKIP      = 3'd3;
  localparam logic [2:0] OP_EMERGENCY = 3'd4;
  localparam logic [2:0] OP_BEGIN     = 3'd5;
  localparam logic [2:0] OP_REPORTED  = 3'd6;
  localparam logic [2:0] OP_RESTART   = 3'd7;

  // Session states
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_VALIDATING = 3'd1;
  localparam logic [2:0] ST_RUNNING    = 3'd2;
  localparam logic [2:0] ST_STOPPING   = 3'd3;
  localparam logic [2:0] ST_COMPLETE   = 3'd4;
  localparam logic [2:0] ST_CANCELING  = 3'd5;
  localparam logic [2:0] ST_SKIPPING   = 3'd6;
  localparam logic [2:0] ST_FAULT      = 3'd7;

  // Lamp commands
  localparam logic [1:0] LAMP_NONE = 2'd0;
  localparam logic [1:0] LAMP_ON   = 2'd1;
  localparam logic [1:0] LAMP_OFF  = 2'd2;

  // Lamp belief
  localparam logic [1:0] BELIEF_UNKNOWN = 2'd0;
  localparam logic [1:0] BELIEF_OFF     = 2'd1;
  localparam logic [1:0] BELIEF_ON      = 2'd2;

  // Terminal outcomes
  localparam logic [2:0] TERM_NONE     = 3'd0;
  localparam logic [2:0] TERM_COMPLETE = 3'd1;
  localparam logic [2:0] TERM_FAULT    = 3'd2;
  localparam logic [2:0] TERM_REJECTED = 3'd3;
  localparam logic [2:0] TERM_CANCELED = 3'd4;
  localparam logic [2:0] TERM_SKIPPED  = 3'd5;

  // Fault kinds and levels
  localparam logic [1:0] FAULT_CLEAR  = 2'd0;
  localparam logic [1:0] FAULT_SAFETY = 2'd1;
  localparam logic [1:0] FAULT_IO     = 2'd2;
  localparam logic       LEVEL_WARNING     = 1'b0;
  localparam logic       LEVEL_RECOVERABLE = 1'b1;

  // Begin status
  localparam logic [1:0] BEGIN_OK       = 2'd0;
  localparam logic [1:0] BEGIN_NOT_IDLE = 2'd1;
  localparam logic [1:0] BEGIN_INVALID  = 2'd2;

  // Position status bits
  localparam int PS_VALID  = 0;
  localparam int PS_FRESH  = 1;
  localparam int PS_STABLE = 2;
  localparam int PS_MOVING = 3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now_time;
    logic [31:0] request_tag;
    logic [31:0] run_length;
    logic        safety_alarm;
    logic [3:0]  position_status;
    logic [2:0]  drum_position;
    logic [1:0]  action_kind;
    logic        action_ok;
  } event_t;

  typedef struct packed {
    logic [2:0] state_after;
    logic [1:0] lamp_command;
    logic [2:0] terminal_kind;
    logic [1:0] fault_kind;
    logic       fault_level;
    logic       report_now;
    logic [1:0] begin_status;
    logic [1:0] lamp_known;
    logic       terminal_pending;
  } result_t;

endpackage

[rtl/uv_lamp_session_controller_core.sv]
// UV lamp session controller: event register, session state update, result register.
// An accepted event waits in the event register and moves on to the result register once that is free.
// Throughput: one event per cycle while out_stall is low; the input and result registers form a two-entry pipe.
// Input stall rises only while the event register is full and the result is held.
// Reset (rst_n low, synchronous) empties both registers, clears the session state
// and sets both configuration registers to zero.
module uv_lamp_session_controller_core #(
  parameter int TIME_BITS = uvlsc_pkg::TIME_BITS_DEF,
  parameter int ID_BITS   = uvlsc_pkg::ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uvlsc_pkg::event_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output uvlsc_pkg::result_t out_data,
  input  logic               cfg_write_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  // Configuration registers
  logic [31:0] max_dur_r;
  logic [2:0]  req_pos_r;

  // Pipe registers
  logic               ev_valid_r;
  uvlsc_pkg::event_t  ev_r;
  logic               out_valid_r;
  uvlsc_pkg::result_t out_r;
  logic               out_free;
  logic               advance;

  // Session state
  logic [2:0]           state_r, state_nxt;
  logic [ID_BITS-1:0]   req_r, req_nxt;
  logic [31:0]          dur_r, dur_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [1:0]           pend_r, pend_nxt;
  logic [1:0]           belief_r, belief_nxt;
  logic [2:0]           term_r, term_nxt;
  logic [1:0]           fault_r, fault_nxt;
  logic                 level_r, level_nxt;
  logic                 reported_r, reported_nxt;

  uvlsc_pkg::result_t res;

  // Event fields at the register widths
  logic [TIME_BITS+31:0] now_wide;
  logic [TIME_BITS-1:0]  now_cut;
  logic [ID_BITS+31:0]   id_wide;
  logic [ID_BITS-1:0]    id_cut;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  run_done;
  logic                  pos_bad;

  assign now_wide = {TIME_BITS'(0), ev_r.now_time};
  assign now_cut  = now_wide[TIME_BITS-1:0];
  assign id_wide  = {ID_BITS'(0), ev_r.request_tag};
  assign id_cut   = id_wide[ID_BITS-1:0];
  assign elapsed  = now_cut - start_r;
  assign run_done = {32'd0, elapsed} >= {TIME_BITS'(0), dur_r};
  assign pos_bad  = !ev_r.position_status[uvlsc_pkg::PS_VALID]
                 || !ev_r.position_status[uvlsc_pkg::PS_FRESH]
                 || !ev_r.position_status[uvlsc_pkg::PS_STABLE]
                 || ev_r.position_status[uvlsc_pkg::PS_MOVING]
                 || (ev_r.drum_position != req_pos_r);

  // Handshake: result register frees when empty or drained
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = ev_valid_r && out_free;
  assign in_stall  = ev_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Apply one event to the session state
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    dur_nxt      = dur_r;
    start_nxt    = start_r;
    pend_nxt     = pend_r;
    belief_nxt   = belief_r;
    term_nxt     = term_r;
    fault_nxt    = fault_r;
    level_nxt    = level_r;
    reported_nxt = reported_r;
    res          = '0;

    unique case (ev_r.operation)
      uvlsc_pkg::OP_TICK: begin
        if (state_r == uvlsc_pkg::ST_VALIDATING) begin
          if (ev_r.safety_alarm) begin
            state_nxt         = uvlsc_pkg::ST_FAULT;
            term_nxt          = uvlsc_pkg::TERM_FAULT;
            fault_nxt         = uvlsc_pkg::FAULT_SAFETY;
            level_nxt         = uvlsc_pkg::LEVEL_RECOVERABLE;
            res.terminal_kind = uvlsc_pkg::TERM_FAULT;
            res.fault_kind    = uvlsc_pkg::FAULT_SAFETY;
            res.fault_level   = uvlsc_pkg::LEVEL_RECOVERABLE;
            res.report_now    = 1'b1;
          end else if (pos_bad) begin
            state_nxt         = uvlsc_pkg::ST_FAULT;
            term_nxt          = uvlsc_pkg::TERM_REJECTED;
            fault_nxt         = uvlsc_pkg::FAULT_CLEAR;
            level_nxt         = uvlsc_pkg::LEVEL_WARNING;
            res.terminal_kind = uvlsc_pkg::TERM_REJECTED;
            res.report_now    = 1'b1;
          end else begin
            state_nxt        = uvlsc_pkg::ST_RUNNING;
            start_nxt        = now_cut;
            pend_nxt         = uvlsc_pkg::LAMP_ON;
            res.lamp_command = uvlsc_pkg::LAMP_ON;
          end
        end else if (state_r == uvlsc_pkg::ST_RUNNING && run_done) begin
          state_nxt        = uvlsc_pkg::ST_STOPPING;
          pend_nxt         = uvlsc_pkg::LAMP_OFF;
          res.lamp_command = uvlsc_pkg::LAMP_OFF;
        end
      end
      uvlsc_pkg::OP_ACTION: begin
        // Only the result of the pending command counts
        if (ev_r.action_kind == pend_r) begin
          pend_nxt = uvlsc_pkg::LAMP_NONE;
          if (pend_r == uvlsc_pkg::LAMP_ON) begin
            if (ev_r.action_ok) begin
              belief_nxt = uvlsc_pkg::BELIEF_ON;
            end else begin
              belief_nxt        = uvlsc_pkg::BELIEF_UNKNOWN;
              state_nxt         = uvlsc_pkg::ST_STOPPING;
              pend_nxt          = uvlsc_pkg::LAMP_OFF;
              res.lamp_command  = uvlsc_pkg::LAMP_OFF;
              term_nxt          = uvlsc_pkg::TERM_FAULT;
              fault_nxt         = uvlsc_pkg::FAULT_IO;
              level_nxt         = uvlsc_pkg::LEVEL_RECOVERABLE;
              res.terminal_kind = uvlsc_pkg::TERM_FAULT;
              res.fault_kind    = uvlsc_pkg::FAULT_IO;
              res.fault_level   = uvlsc_pkg::LEVEL_RECOVERABLE;
              res.report_now    = 1'b1;
            end
          end else if (pend_r == uvlsc_pkg::LAMP_OFF) begin
            belief_nxt = ev_r.action_ok ? uvlsc_pkg::BELIEF_OFF : uvlsc_pkg::BELIEF_UNKNOWN;
            if (state_r == uvlsc_pkg::ST_STOPPING) begin
              state_nxt = uvlsc_pkg::ST_COMPLETE;
              if (term_r == uvlsc_pkg::TERM_NONE) begin
                term_nxt          = uvlsc_pkg::TERM_COMPLETE;
                fault_nxt         = uvlsc_pkg::FAULT_CLEAR;
                level_nxt         = uvlsc_pkg::LEVEL_WARNING;
                res.terminal_kind = uvlsc_pkg::TERM_COMPLETE;
                res.report_now    = 1'b1;
              end else begin
                // Repeat the stored outcome, emit only if not yet reported
                res.terminal_kind = term_r;
                res.fault_kind    = fault_r;
                res.fault_level   = level_r;
                res.report_now    = !reported_r;
              end
            end else if (state_r == uvlsc_pkg::ST_CANCELING) begin
              state_nxt         = uvlsc_pkg::ST_COMPLETE;
              term_nxt          = uvlsc_pkg::TERM_CANCELED;
              fault_nxt         = uvlsc_pkg::FAULT_CLEAR;
              level_nxt         = uvlsc_pkg::LEVEL_WARNING;
              res.terminal_kind = uvlsc_pkg::TERM_CANCELED;
              res.report_now    = 1'b1;
            end else if (state_r == uvlsc_pkg::ST_SKIPPING) begin
              state_nxt         = uvlsc_pkg::ST_COMPLETE;
              term_nxt          = uvlsc_pkg::TERM_SKIPPED;
              fault_nxt         = uvlsc_pkg::FAULT_CLEAR;
              level_nxt         = uvlsc_pkg::LEVEL_WARNING;
              res.terminal_kind = uvlsc_pkg::TERM_SKIPPED;
              res.report_now    = 1'b1;
            end
          end
        end
      end
      uvlsc_pkg::OP_CANCEL, uvlsc_pkg::OP_SKIP: begin
        if (id_cut == req_r && (state_r == uvlsc_pkg::ST_VALIDATING ||
                                state_r == uvlsc_pkg::ST_RUNNING)) begin
          state_nxt        = (ev_r.operation == uvlsc_pkg::OP_CANCEL) ?
                             uvlsc_pkg::ST_CANCELING : uvlsc_pkg::ST_SKIPPING;
          pend_nxt         = uvlsc_pkg::LAMP_OFF;
          res.lamp_command = uvlsc_pkg::LAMP_OFF;
        end
      end
      uvlsc_pkg::OP_EMERGENCY: begin
        if (state_r != uvlsc_pkg::ST_IDLE && state_r != uvlsc_pkg::ST_COMPLETE &&
            state_r != uvlsc_pkg::ST_FAULT) begin
          state_nxt         = uvlsc_pkg::ST_STOPPING;
          pend_nxt          = uvlsc_pkg::LAMP_OFF;
          res.lamp_command  = uvlsc_pkg::LAMP_OFF;
          term_nxt          = uvlsc_pkg::TERM_FAULT;
          fault_nxt         = uvlsc_pkg::FAULT_SAFETY;
          level_nxt         = uvlsc_pkg::LEVEL_RECOVERABLE;
          res.terminal_kind = uvlsc_pkg::TERM_FAULT;
          res.fault_kind    = uvlsc_pkg::FAULT_SAFETY;
          res.fault_level   = uvlsc_pkg::LEVEL_RECOVERABLE;
          res.report_now    = 1'b1;
        end
      end
      uvlsc_pkg::OP_BEGIN: begin
        if (state_r != uvlsc_pkg::ST_IDLE) begin
          res.begin_status = uvlsc_pkg::BEGIN_NOT_IDLE;
        end else if (id_cut == '0 || ev_r.run_length == 32'd0 ||
                     ev_r.run_length > max_dur_r) begin
          res.begin_status = uvlsc_pkg::BEGIN_INVALID;
        end else begin
          req_nxt      = id_cut;
          dur_nxt      = ev_r.run_length;
          state_nxt    = uvlsc_pkg::ST_VALIDATING;
          start_nxt    = now_cut;
          reported_nxt = 1'b0;
          term_nxt     = uvlsc_pkg::TERM_NONE;
          pend_nxt     = uvlsc_pkg::LAMP_NONE;
          fault_nxt    = uvlsc_pkg::FAULT_CLEAR;
          level_nxt    = uvlsc_pkg::LEVEL_WARNING;
        end
      end
      uvlsc_pkg::OP_REPORTED: begin
        reported_nxt = 1'b1;
      end
      uvlsc_pkg::OP_RESTART: begin
        state_nxt    = uvlsc_pkg::ST_IDLE;
        req_nxt      = '0;
        dur_nxt      = '0;
        start_nxt    = '0;
        pend_nxt     = uvlsc_pkg::LAMP_NONE;
        belief_nxt   = uvlsc_pkg::BELIEF_OFF;
        term_nxt     = uvlsc_pkg::TERM_NONE;
        fault_nxt    = uvlsc_pkg::FAULT_CLEAR;
        level_nxt    = uvlsc_pkg::LEVEL_WARNING;
        reported_nxt = 1'b0;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase

    res.state_after      = state_nxt;
    res.lamp_known       = belief_nxt;
    res.terminal_pending = !reported_nxt && (term_nxt != uvlsc_pkg::TERM_NONE);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dur_r <= '0;
      req_pos_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        uvlsc_pkg::CFG_MAX_DURATION: max_dur_r <= cfg_wdata;
        uvlsc_pkg::CFG_REQUIRED_POS: req_pos_r <= cfg_wdata[2:0];
        default: max_dur_r <= max_dur_r;
      endcase
    end
  end

  // Event register: load on transfer, drop when it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ev_valid_r <= 1'b1;
    end else if (advance) begin
      ev_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ev_r <= in_data;
    end
  end

  // Result register: load on advance, drop when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  // Session state: commit on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= uvlsc_pkg::ST_IDLE;
      req_r      <= '0;
      dur_r      <= '0;
      start_r    <= '0;
      pend_r     <= uvlsc_pkg::LAMP_NONE;
      belief_r   <= uvlsc_pkg::BELIEF_OFF;
      term_r     <= uvlsc_pkg::TERM_NONE;
      fault_r    <= uvlsc_pkg::FAULT_CLEAR;
      level_r    <= uvlsc_pkg::LEVEL_WARNING;
      reported_r <= 1'b0;
    end else if (advance) begin
      state_r    <= state_nxt;
      req_r      <= req_nxt;
      dur_r      <= dur_nxt;
      start_r    <= start_nxt;
      pend_r     <= pend_nxt;
      belief_r   <= belief_nxt;
      term_r     <= term_nxt;
      fault_r    <= fault_nxt;
      level_r    <= level_nxt;
      reported_r <= reported_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_has_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.report_now |-> out_r.terminal_kind != uvlsc_pkg::TERM_NONE)
    else $error("emitted result without a terminal outcome");

  a_on_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.lamp_command == uvlsc_pkg::LAMP_ON |->
      out_r.state_after == uvlsc_pkg::ST_RUNNING)
    else $error("lamp on commanded outside running");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == uvlsc_pkg::ST_IDLE |-> pend_r == uvlsc_pkg::LAMP_NONE)
    else $error("lamp command pending while idle");

  a_begin_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.begin_status != uvlsc_pkg::BEGIN_OK |->
      out_r.lamp_command == uvlsc_pkg::LAMP_NONE && !out_r.report_now)
    else $error("refused begin produced a command or event");

  a_state_holds_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r) || !rst_n)
    else $error("session state changed without an event");
`endif

endmodule

[bench/testbench.sv]
// Self-checking testbench for the UV lamp session controller core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 5;
  localparam int HOLD_CYCLES    = 64;
  // valid, fresh and stable set, motor not moving
  localparam logic [3:0] PS_READY = 4'b0111;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  uvlsc_pkg::event_t   in_data      = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  uvlsc_pkg::result_t  out_data;
  logic                cfg_write_en = 1'b0;
  logic                cfg_index    = uvlsc_pkg::CFG_MAX_DURATION;
  logic [31:0]         cfg_wdata    = '0;

  uv_lamp_session_controller_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Session model: configuration copy and state
  logic [31:0] lim_duration  = '0;
  logic [2:0]  need_position = '0;
  logic [2:0]  sess_state;
  logic [31:0] sess_tag;
  logic [31:0] sess_len;
  logic [31:0] sess_t0;
  logic [1:0]  sess_cmd;
  logic [1:0]  lamp_belief;
  logic [2:0]  kept_term;
  logic [1:0]  kept_fault;
  logic        kept_level;
  logic        term_acked;

  uvlsc_pkg::result_t expected_results[$];
  int      mismatches    = 0;
  int      idle_cycles   = 0;
  int      result_gap    = 0;
  int      hold_left     = 0;
  int      events_sent   = 0;
  bit      sender_idles  = 1'b1;
  bit      receiver_idles = 1'b1;
  logic [31:0] wall_ms   = '0;

  function automatic void clear_session();
    sess_state  = uvlsc_pkg::ST_IDLE;
    sess_tag    = '0;
    sess_len    = '0;
    sess_t0     = '0;
    sess_cmd    = uvlsc_pkg::LAMP_NONE;
    lamp_belief = uvlsc_pkg::BELIEF_OFF;
    kept_term   = uvlsc_pkg::TERM_NONE;
    kept_fault  = uvlsc_pkg::FAULT_CLEAR;
    kept_level  = uvlsc_pkg::LEVEL_WARNING;
    term_acked  = 1'b0;
  endfunction

  function automatic void raise_outcome(inout uvlsc_pkg::result_t r,
                                        input logic [2:0] term,
                                        input logic [1:0] fault, input logic level);
    kept_term       = term;
    kept_fault      = fault;
    kept_level      = level;
    r.terminal_kind = term;
    r.fault_kind    = fault;
    r.fault_level   = level;
    r.report_now    = 1'b1;
  endfunction

  function automatic void command_off(inout uvlsc_pkg::result_t r, input logic [2:0] st);
    sess_state     = st;
    r.lamp_command = uvlsc_pkg::LAMP_OFF;
    sess_cmd       = uvlsc_pkg::LAMP_OFF;
  endfunction

  // Advance the session model by one event and return the result it gives
  function automatic uvlsc_pkg::result_t predict_result(input uvlsc_pkg::event_t ev);
    uvlsc_pkg::result_t r;
    logic [31:0]        elapsed;
    logic [1:0]         done;
    r = '0;
    case (ev.operation)
      uvlsc_pkg::OP_TICK: begin
        if (sess_state == uvlsc_pkg::ST_VALIDATING) begin
          if (ev.safety_alarm) begin
            sess_state = uvlsc_pkg::ST_FAULT;
            raise_outcome(r, uvlsc_pkg::TERM_FAULT, uvlsc_pkg::FAULT_SAFETY,
                          uvlsc_pkg::LEVEL_RECOVERABLE);
          end else if (ev.position_status != PS_READY ||
                       ev.drum_position != need_position) begin
            sess_state = uvlsc_pkg::ST_FAULT;
            raise_outcome(r, uvlsc_pkg::TERM_REJECTED, uvlsc_pkg::FAULT_CLEAR,
                          uvlsc_pkg::LEVEL_WARNING);
          end else begin
            sess_state     = uvlsc_pkg::ST_RUNNING;
            sess_t0        = ev.now_time;
            r.lamp_command = uvlsc_pkg::LAMP_ON;
            sess_cmd       = uvlsc_pkg::LAMP_ON;
          end
        end else if (sess_state == uvlsc_pkg::ST_RUNNING) begin
          elapsed = ev.now_time - sess_t0;
          if (elapsed >= sess_len) command_off(r, uvlsc_pkg::ST_STOPPING);
        end
      end
      uvlsc_pkg::OP_ACTION: begin
        if (ev.action_kind == sess_cmd) begin
          done     = sess_cmd;
          sess_cmd = uvlsc_pkg::LAMP_NONE;
          if (done == uvlsc_pkg::LAMP_ON) begin
            if (ev.action_ok) begin
              lamp_belief = uvlsc_pkg::BELIEF_ON;
            end else begin
              lamp_belief = uvlsc_pkg::BELIEF_UNKNOWN;
              command_off(r, uvlsc_pkg::ST_STOPPING);
              raise_outcome(r, uvlsc_pkg::TERM_FAULT, uvlsc_pkg::FAULT_IO,
                            uvlsc_pkg::LEVEL_RECOVERABLE);
            end
          end else if (done == uvlsc_pkg::LAMP_OFF) begin
            lamp_belief = ev.action_ok ? uvlsc_pkg::BELIEF_OFF : uvlsc_pkg::BELIEF_UNKNOWN;
            case (sess_state)
              uvlsc_pkg::ST_STOPPING: begin
                sess_state = uvlsc_pkg::ST_COMPLETE;
                // repeat an outcome raised earlier, else report completion
                if (kept_term == uvlsc_pkg::TERM_NONE) begin
                  raise_outcome(r, uvlsc_pkg::TERM_COMPLETE, uvlsc_pkg::FAULT_CLEAR,
                                uvlsc_pkg::LEVEL_WARNING);
                end else begin
                  r.terminal_kind = kept_term;
                  r.fault_kind    = kept_fault;
                  r.fault_level   = kept_level;
                  r.report_now    = !term_acked;
                end
              end
              uvlsc_pkg::ST_CANCELING: begin
                sess_state = uvlsc_pkg::ST_COMPLETE;
                raise_outcome(r, uvlsc_pkg::TERM_CANCELED, uvlsc_pkg::FAULT_CLEAR,
                              uvlsc_pkg::LEVEL_WARNING);
              end
              uvlsc_pkg::ST_SKIPPING: begin
                sess_state = uvlsc_pkg::ST_COMPLETE;
                raise_outcome(r, uvlsc_pkg::TERM_SKIPPED, uvlsc_pkg::FAULT_CLEAR,
                              uvlsc_pkg::LEVEL_WARNING);
              end
              default: ;
            endcase
          end
        end
      end
      uvlsc_pkg::OP_CANCEL, uvlsc_pkg::OP_SKIP: begin
        if (ev.request_tag == sess_tag &&
            (sess_state == uvlsc_pkg::ST_VALIDATING || sess_state == uvlsc_pkg::ST_RUNNING))
          command_off(r, (ev.operation == uvlsc_pkg::OP_CANCEL) ?
                         uvlsc_pkg::ST_CANCELING : uvlsc_pkg::ST_SKIPPING);
      end
      uvlsc_pkg::OP_EMERGENCY: begin
        if (sess_state != uvlsc_pkg::ST_IDLE && sess_state != uvlsc_pkg::ST_COMPLETE &&
            sess_state != uvlsc_pkg::ST_FAULT) begin
          command_off(r, uvlsc_pkg::ST_STOPPING);
          raise_outcome(r, uvlsc_pkg::TERM_FAULT, uvlsc_pkg::FAULT_SAFETY,
                        uvlsc_pkg::LEVEL_RECOVERABLE);
        end
      end
      uvlsc_pkg::OP_BEGIN: begin
        if (sess_state != uvlsc_pkg::ST_IDLE) begin
          r.begin_status = uvlsc_pkg::BEGIN_NOT_IDLE;
        end else if (ev.request_tag == '0 || ev.run_length == '0 ||
                     ev.run_length > lim_duration) begin
          r.begin_status = uvlsc_pkg::BEGIN_INVALID;
        end else begin
          sess_tag   = ev.request_tag;
          sess_len   = ev.run_length;
          sess_state = uvlsc_pkg::ST_VALIDATING;
          sess_t0    = ev.now_time;
          term_acked = 1'b0;
          kept_term  = uvlsc_pkg::TERM_NONE;
          sess_cmd   = uvlsc_pkg::LAMP_NONE;
          kept_fault = uvlsc_pkg::FAULT_CLEAR;
          kept_level = uvlsc_pkg::LEVEL_WARNING;
        end
      end
      uvlsc_pkg::OP_REPORTED: term_acked = 1'b1;
      default: clear_session();
    endcase
    r.state_after      = sess_state;
    r.lamp_known       = lamp_belief;
    r.terminal_pending = !term_acked && kept_term != uvlsc_pkg::TERM_NONE;
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    $error("%s: expected %0h, got %0h", name, want, got);
    mismatches++;
  endtask

  task automatic check_result(input uvlsc_pkg::result_t want, input uvlsc_pkg::result_t got);
    if (got.state_after !== want.state_after)
      flag_field("state_after", 32'(want.state_after), 32'(got.state_after));
    if (got.lamp_command !== want.lamp_command)
      flag_field("lamp_command", 32'(want.lamp_command), 32'(got.lamp_command));
    if (got.terminal_kind !== want.terminal_kind)
      flag_field("terminal_kind", 32'(want.terminal_kind), 32'(got.terminal_kind));
    if (got.fault_kind !== want.fault_kind)
      flag_field("fault_kind", 32'(want.fault_kind), 32'(got.fault_kind));
    if (got.fault_level !== want.fault_level)
      flag_field("fault_level", 32'(want.fault_level), 32'(got.fault_level));
    if (got.report_now !== want.report_now)
      flag_field("report_now", 32'(want.report_now), 32'(got.report_now));
    if (got.begin_status !== want.begin_status)
      flag_field("begin_status", 32'(want.begin_status), 32'(got.begin_status));
    if (got.lamp_known !== want.lamp_known)
      flag_field("lamp_known", 32'(want.lamp_known), 32'(got.lamp_known));
    if (got.terminal_pending !== want.terminal_pending)
      flag_field("terminal_pending", 32'(want.terminal_pending),
                 32'(got.terminal_pending));
  endtask

  // Check results, predict accepted events and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no event waiting for it");
          mismatches++;
        end else begin
          check_result(expected_results.pop_front(), out_data);
        end
        result_gap = receiver_idles ? $urandom_range(0, 9) : 0;
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(in_data));
      if ((out_valid && !out_stall) || (in_valid && !in_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Hold off results: a long requested stretch first, else the drawn gap
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (result_gap > 0) begin
      out_stall <= 1'b1;
      result_gap--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(input uvlsc_pkg::event_t ev);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    events_sent++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    go_quiet();
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (idx == uvlsc_pkg::CFG_MAX_DURATION)
      lim_duration = value;
    else
      need_position = value[2:0];
  endtask

  // Event with every field random except the operation
  function automatic uvlsc_pkg::event_t noise_event(input logic [2:0] op);
    uvlsc_pkg::event_t ev;
    ev.operation       = op;
    ev.now_time        = $urandom;
    ev.request_tag     = $urandom;
    ev.run_length      = $urandom;
    ev.safety_alarm    = 1'($urandom_range(0, 1));
    ev.position_status = 4'($urandom_range(0, 15));
    ev.drum_position   = 3'($urandom_range(0, 7));
    ev.action_kind     = 2'($urandom_range(0, 2));
    ev.action_ok       = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  task automatic send_begin(input logic [31:0] tag, input logic [31:0] len,
                            input logic [31:0] now);
    uvlsc_pkg::event_t ev;
    ev             = noise_event(uvlsc_pkg::OP_BEGIN);
    ev.request_tag = tag;
    ev.run_length  = len;
    ev.now_time    = now;
    send_event(ev);
  endtask

  task automatic send_tick(input logic [31:0] now, input logic alarm,
                           input logic [3:0] ps, input logic [2:0] pos);
    uvlsc_pkg::event_t ev;
    ev                 = noise_event(uvlsc_pkg::OP_TICK);
    ev.now_time        = now;
    ev.safety_alarm    = alarm;
    ev.position_status = ps;
    ev.drum_position   = pos;
    send_event(ev);
  endtask

  task automatic send_lamp_result(input logic [1:0] kind, input logic ok);
    uvlsc_pkg::event_t ev;
    ev             = noise_event(uvlsc_pkg::OP_ACTION);
    ev.action_kind = kind;
    ev.action_ok   = ok;
    send_event(ev);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [31:0] tag);
    uvlsc_pkg::event_t ev;
    ev             = noise_event(op);
    ev.request_tag = tag;
    send_event(ev);
  endtask

  // Tick with random alarm and position report
  task automatic send_random_tick(input logic [31:0] now);
    send_tick(now, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
              3'($urandom_range(0, 7)));
  endtask

  // Zero limit, each refusal reason, begin while busy, alarm on validation
  task automatic test_begin_checks();
    send_begin(32'd5, 32'd1, 32'd0);
    write_register(uvlsc_pkg::CFG_MAX_DURATION, 32'd1000);
    write_register(uvlsc_pkg::CFG_REQUIRED_POS, 32'hFFFF_FFFB);
    send_begin(32'd0, 32'd10, 32'd0);
    send_begin(32'd5, 32'd0, 32'd0);
    send_begin(32'd5, 32'd1001, 32'd0);
    send_begin(32'hFFFF_FFFF, 32'd1000, 32'hFFFF_FFF0);
    send_begin(32'd6, 32'd1, 32'd0);
    send_tick(32'hFFFF_FFF8, 1'b1, PS_READY, need_position);
    send_op(uvlsc_pkg::OP_RESTART, 32'd0);
  endtask

  // Full run whose end time lies across the counter wrap
  task automatic test_timed_run();
    send_begin(32'd7, 32'd1000, 32'd0);
    send_tick(32'hFFFF_FF00, 1'b0, PS_READY, need_position);
    send_lamp_result(uvlsc_pkg::LAMP_OFF, 1'b1);
    send_lamp_result(uvlsc_pkg::LAMP_ON, 1'b1);
    send_tick(32'hFFFF_FF00 + 32'd999, 1'b0, 4'b0000, 3'd0);
    send_tick(32'hFFFF_FF00 + 32'd1000, 1'b1, 4'b1111, 3'd7);
    send_lamp_result(uvlsc_pkg::LAMP_OFF, 1'b1);
  endtask

  // Rejected position report, lamp driver failures, stray result while idle
  task automatic test_fault_paths();
    send_op(uvlsc_pkg::OP_RESTART, 32'd0);
    send_begin(32'd9, 32'd5, 32'd0);
    send_tick(32'd10, 1'b0, 4'b1111, need_position);
    send_op(uvlsc_pkg::OP_RESTART, 32'd0);
    send_begin(32'd9, 32'd5, 32'd20);
    send_tick(32'd30, 1'b0, PS_READY, need_position);
    send_lamp_result(uvlsc_pkg::LAMP_ON, 1'b0);
    send_op(uvlsc_pkg::OP_REPORTED, 32'd0);
    send_lamp_result(uvlsc_pkg::LAMP_OFF, 1'b0);
    send_op(uvlsc_pkg::OP_RESTART, 32'd0);
    send_lamp_result(uvlsc_pkg::LAMP_NONE, 1'b1);
  endtask

  // Cancel with a foreign id, then with the right one while validating
  task automatic test_cancel();
    send_begin(32'd11, 32'd100, 32'd0);
    send_op(uvlsc_pkg::OP_CANCEL, 32'd12);
    send_op(uvlsc_pkg::OP_CANCEL, 32'd11);
    send_lamp_result(uvlsc_pkg::LAMP_OFF, 1'b1);
    send_op(uvlsc_pkg::OP_RESTART, 32'd0);
  endtask

  // Hold results back while events keep coming so the input stalls
  task automatic test_backpressure();
    go_quiet();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (12) send_event(noise_event(3'($urandom_range(0, 7))));
  endtask

  // Wind down a session that has commanded the lamp off
  task automatic finish_stop();
    if ($urandom_range(0, 2) == 0)
      send_random_tick($urandom);
    if ($urandom_range(0, 5) == 0) send_op(uvlsc_pkg::OP_EMERGENCY, $urandom);
    if ($urandom_range(0, 3) == 0) send_op(uvlsc_pkg::OP_REPORTED, $urandom);
    send_lamp_result(uvlsc_pkg::LAMP_OFF, $urandom_range(0, 9) != 0);
    if ($urandom_range(0, 1) == 0) send_op(uvlsc_pkg::OP_REPORTED, $urandom);
  endtask

  // One well-formed session with random content and occasional detours
  task automatic run_session();
    logic [31:0] tag;
    logic [31:0] len;
    logic [31:0] t_start;
    logic [31:0] extra;
    logic [2:0]  stop_op;
    send_op(uvlsc_pkg::OP_RESTART, $urandom);
    tag = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
    if (tag == '0) tag = 32'd1;
    if (lim_duration == '0) begin
      len = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: len = lim_duration;
        1: len = 32'd1 + ($urandom % lim_duration);
        default: len = 32'd1 + $urandom_range(0, (lim_duration > 64) ? 63 : lim_duration - 1);
      endcase
    end
    if ($urandom_range(0, 3) == 0)
      wall_ms = $urandom;
    else
      wall_ms = wall_ms + $urandom_range(0, 1000);

    // refused begin ahead of the real one
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: send_begin(32'd0, len, wall_ms);
        1: send_begin(tag, 32'd0, wall_ms);
        default: send_begin(tag, lim_duration + 32'd1, wall_ms);
      endcase
    end
    send_begin(tag, len, wall_ms);
    if (lim_duration == '0) return;
    if ($urandom_range(0, 9) == 0) send_begin($urandom, len, wall_ms);

    // leave while still validating
    if ($urandom_range(0, 9) == 0) begin
      send_op($urandom_range(0, 1) ? uvlsc_pkg::OP_CANCEL : uvlsc_pkg::OP_SKIP, tag);
      finish_stop();
      return;
    end

    // position check
    wall_ms = wall_ms + $urandom_range(0, 50);
    if ($urandom_range(0, 6) == 0) begin
      send_random_tick(wall_ms);
      if ($urandom_range(0, 1) == 0) send_op(uvlsc_pkg::OP_EMERGENCY, $urandom);
      if ($urandom_range(0, 1) == 0) send_op(uvlsc_pkg::OP_REPORTED, $urandom);
      return;
    end
    send_tick(wall_ms, 1'b0, PS_READY, need_position);
    t_start = wall_ms;

    // lamp on confirmation, sometimes after a stray result or as a failure
    if ($urandom_range(0, 7) == 0)
      send_lamp_result($urandom_range(0, 1) ? uvlsc_pkg::LAMP_OFF : uvlsc_pkg::LAMP_NONE,
                       1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0) begin
      send_lamp_result(uvlsc_pkg::LAMP_ON, 1'b0);
      finish_stop();
      return;
    end
    send_lamp_result(uvlsc_pkg::LAMP_ON, 1'b1);

    // ticks inside the run time
    repeat ($urandom_range(0, 3))
      send_random_tick(t_start + $urandom_range(0, len - 1));

    // end of the run
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        stop_op = ($urandom_range(0, 1) == 0) ? uvlsc_pkg::OP_CANCEL : uvlsc_pkg::OP_SKIP;
        if ($urandom_range(0, 2) == 0) send_op(stop_op, tag + 32'd1);
        send_op(stop_op, tag);
      end
      4: send_op(uvlsc_pkg::OP_EMERGENCY, $urandom);
      default: begin
        extra = (len > 32'hFFFF_FF00) ? 32'd0 : $urandom_range(0, 255);
        send_random_tick(t_start + len + extra);
      end
    endcase
    finish_stop();
  endtask

  task automatic test_random_traffic(input logic [31:0] limit, input logic [2:0] pos,
                                     input int count, input bit sidle, input bit ridle);
    logic [31:0] pos_word;
    int          target;
    pos_word      = $urandom;
    pos_word[2:0] = pos;
    write_register(uvlsc_pkg::CFG_MAX_DURATION, limit);
    write_register(uvlsc_pkg::CFG_REQUIRED_POS, pos_word);
    sender_idles   = sidle;
    receiver_idles = ridle;
    target = events_sent + count;
    while (events_sent < target) begin
      if ($urandom_range(0, 6) == 0)
        send_event(noise_event(3'($urandom_range(0, 7))));
      else
        run_session();
    end
  endtask

  initial begin
    clear_session();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_begin_checks();
    test_timed_run();
    test_fault_paths();
    test_cancel();
    test_backpressure();
    test_random_traffic(32'd0, 3'd0, 80, 1'b1, 1'b1);
    test_random_traffic(32'hFFFF_FFFF, 3'd7, 350, 1'b0, 1'b0);
    test_random_traffic($urandom_range(1, 200), 3'($urandom_range(0, 7)), 350, 1'b1, 1'b0);
    test_random_traffic(32'd1, 3'd0, 200, 1'b0, 1'b1);
    test_random_traffic($urandom, 3'($urandom_range(0, 7)), 470, 1'b1, 1'b1);

    go_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
